// ===== src/ptab_pkg.sv =====
// ============================================================================
// ptab_pkg: shared types and constants of the page table engine
// Sizes of the directory and table stores, entry layouts, operation and
// status codes, and the request bundles that go to the two memories.
// ============================================================================
package ptab_pkg;

    // Store sizes.
    localparam int DIR_ENTRIES          = 1024;
    localparam int RESERVED_DIR_ENTRIES = 1;
    localparam int TABLE_SLOTS          = 16;
    localparam int TABLE_ENTRIES        = 1024;

    // Address field layout.
    localparam int DIR_AW     = 10;
    localparam int IDX_W      = 10;
    localparam int PAGE_SHIFT = 12;
    localparam int DIR_SHIFT  = 22;
    localparam int FRAME_W    = 20;
    localparam int ADDR_W     = 32;

    // Derived widths of the slot number, the slot counter and the table address, and the table store depth.
    localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);
    localparam int TBL_DEPTH = TABLE_SLOTS * TABLE_ENTRIES;
    localparam int TBL_AW    = SLOT_W + IDX_W;

    // First directory index that map and unmap refuse.
    localparam logic [DIR_AW:0] RSV_BASE = (DIR_AW + 1)'(DIR_ENTRIES - RESERVED_DIR_ENTRIES);

    // Operation codes.
    typedef enum logic [1:0] {
        OP_MAP   = 2'd0,
        OP_UNMAP = 2'd1,
        OP_XLATE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Status codes.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_MISALIGNED = 3'd1,
        ST_RESERVED   = 3'd2,
        ST_ALREADY    = 3'd3,
        ST_NOT_MAPPED = 3'd4,
        ST_NO_SLOT    = 3'd5
    } status_t;

    // Directory entry: present bit and table slot number.
    typedef struct packed {
        logic              present;
        logic [SLOT_W-1:0] slot;
    } dir_entry_t;

    localparam int DIR_W = $bits(dir_entry_t);

    // Table entry, laid out as present, user, writable, frame from the top down.
    typedef struct packed {
        logic               present;
        logic               user;
        logic               writable;
        logic [FRAME_W-1:0] frame;
    } tbl_entry_t;

    localparam int TBL_W = $bits(tbl_entry_t);

    // Memory requests issued by the controller.
    typedef struct packed {
        logic              we;
        logic              re;
        logic [DIR_AW-1:0] addr;
        dir_entry_t        wdata;
    } dir_req_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [TBL_AW-1:0] addr;
        tbl_entry_t        wdata;
    } tbl_req_t;

endpackage

// ===== src/ptab_ram.sv =====
// ============================================================================
// ptab_ram: single-port synchronous RAM
// One address per cycle, write or read, with the read data registered.
// ============================================================================
module ptab_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port share the address.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ptab_ctrl.sv =====
// ============================================================================
// ptab_ctrl: walk sequencer of the page table engine
// Clears both stores after reset, then runs each transaction as a directory
// read, then, unless it ends there, an optional slot allocation and a table
// read with a write back for map and unmap; keeps the result in an output register.
// ============================================================================
module ptab_ctrl
    import ptab_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // Input transaction.
    input  logic               in_valid,
    output logic               in_ready,
    input  op_t                in_op,
    input  logic [ADDR_W-1:0]  in_va,
    input  logic [ADDR_W-1:0]  in_pa,
    input  logic [1:0]         in_flags,
    // Result transaction.
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  out_addr,
    output logic [1:0]         out_flags,
    output status_t            out_status,
    // Memory side.
    output dir_req_t           dir_req,
    input  dir_entry_t         dir_rdata,
    output tbl_req_t           tbl_req,
    input  tbl_entry_t         tbl_rdata
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_TBL
    } state_t;

    state_t              state_reg, state_next;
    logic [TBL_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]    free_reg, free_next;
    op_t                 op_reg, op_next;
    logic [ADDR_W-1:0]   va_reg, va_next;
    logic [ADDR_W-1:0]   pa_reg, pa_next;
    logic [1:0]          fl_reg, fl_next;
    logic [TBL_AW-1:0]   taddr_reg, taddr_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [1:0]          out_flags_reg, out_flags_next;
    status_t             out_status_reg, out_status_next;

    logic                out_free;
    logic                accept;
    logic [DIR_AW-1:0]   dir_idx;
    logic [IDX_W-1:0]    tbl_idx;
    logic                va_mis;
    logic                pa_mis;
    logic                reserved;
    logic                pool_full;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    assign dir_idx   = va_reg[DIR_SHIFT +: DIR_AW];
    assign tbl_idx   = va_reg[PAGE_SHIFT +: IDX_W];
    assign va_mis    = (va_reg[PAGE_SHIFT-1:0] != '0);
    assign pa_mis    = (pa_reg[PAGE_SHIFT-1:0] != '0);
    assign reserved  = ({1'b0, dir_idx} >= RSV_BASE);
    assign pool_full = (free_reg >= CNT_W'(TABLE_SLOTS));

    // Next-state, memory request and result logic.
    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        free_next       = free_reg;
        op_next         = op_reg;
        va_next         = va_reg;
        pa_next         = pa_reg;
        fl_next         = fl_reg;
        taddr_next      = taddr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_addr_next   = out_addr_reg;
        out_flags_next  = out_flags_reg;
        out_status_next = out_status_reg;
        dir_req         = '0;
        tbl_req         = '0;

        case (state_reg)
            // Zero both stores, one table entry and one directory entry a cycle.
            S_CLEAR: begin
                dir_req.we   = 1'b1;
                dir_req.addr = clr_cnt_reg[DIR_AW-1:0];
                tbl_req.we   = 1'b1;
                tbl_req.addr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + TBL_AW'(1);
                if (clr_cnt_reg == TBL_AW'(TBL_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end

            // Take a transaction and start its directory read.
            S_IDLE: begin
                if (accept) begin
                    op_next      = in_op;
                    va_next      = in_va;
                    pa_next      = in_pa;
                    fl_next      = in_flags;
                    dir_req.re   = 1'b1;
                    dir_req.addr = in_va[DIR_SHIFT +: DIR_AW];
                    state_next   = S_DIR;
                end
            end

            // Directory entry is here: finish early or start the table read.
            S_DIR: begin
                case (op_reg)
                    OP_MAP: begin
                        if (va_mis || pa_mis || reserved ||
                            (!dir_rdata.present && pool_full)) begin
                            if (out_free) begin
                                out_valid_next = 1'b1;
                                out_addr_next  = '0;
                                out_flags_next = '0;
                                if (va_mis || pa_mis) begin
                                    out_status_next = ST_MISALIGNED;
                                end else if (reserved) begin
                                    out_status_next = ST_RESERVED;
                                end else begin
                                    out_status_next = ST_NO_SLOT;
                                end
                                state_next = S_IDLE;
                            end
                        end else if (!dir_rdata.present) begin
                            // Allocate the next slot; its table is still all zero.
                            dir_req.we            = 1'b1;
                            dir_req.addr          = dir_idx;
                            dir_req.wdata.present = 1'b1;
                            dir_req.wdata.slot    = free_reg[SLOT_W-1:0];
                            free_next             = free_reg + CNT_W'(1);
                            tbl_req.re            = 1'b1;
                            tbl_req.addr          = {free_reg[SLOT_W-1:0], tbl_idx};
                            taddr_next            = {free_reg[SLOT_W-1:0], tbl_idx};
                            state_next            = S_TBL;
                        end else begin
                            tbl_req.re   = 1'b1;
                            tbl_req.addr = {dir_rdata.slot, tbl_idx};
                            taddr_next   = {dir_rdata.slot, tbl_idx};
                            state_next   = S_TBL;
                        end
                    end
                    OP_UNMAP, OP_XLATE: begin
                        if ((op_reg == OP_UNMAP && (va_mis || reserved)) ||
                            !dir_rdata.present) begin
                            if (out_free) begin
                                out_valid_next = 1'b1;
                                out_addr_next  = '0;
                                out_flags_next = '0;
                                if (op_reg == OP_UNMAP && va_mis) begin
                                    out_status_next = ST_MISALIGNED;
                                end else if (op_reg == OP_UNMAP && reserved) begin
                                    out_status_next = ST_RESERVED;
                                end else begin
                                    out_status_next = ST_NOT_MAPPED;
                                end
                                state_next = S_IDLE;
                            end
                        end else begin
                            tbl_req.re   = 1'b1;
                            tbl_req.addr = {dir_rdata.slot, tbl_idx};
                            taddr_next   = {dir_rdata.slot, tbl_idx};
                            state_next   = S_TBL;
                        end
                    end
                    default: begin
                        // Unused operation code: no effect, all-zero result.
                        if (out_free) begin
                            out_valid_next  = 1'b1;
                            out_addr_next   = '0;
                            out_flags_next  = '0;
                            out_status_next = ST_OK;
                            state_next      = S_IDLE;
                        end
                    end
                endcase
            end

            // Table entry is here: modify and write back for map and unmap, and post the result.
            S_TBL: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = '0;
                    out_flags_next  = '0;
                    out_status_next = ST_OK;
                    state_next      = S_IDLE;
                    tbl_req.addr    = taddr_reg;
                    case (op_reg)
                        OP_MAP: begin
                            if (tbl_rdata.present) begin
                                out_status_next = ST_ALREADY;
                            end else begin
                                tbl_req.we               = 1'b1;
                                tbl_req.wdata.present    = 1'b1;
                                tbl_req.wdata.user       = fl_reg[1];
                                tbl_req.wdata.writable   = fl_reg[0];
                                tbl_req.wdata.frame      = pa_reg[PAGE_SHIFT +: FRAME_W];
                            end
                        end
                        OP_UNMAP: begin
                            if (!tbl_rdata.present) begin
                                out_status_next = ST_NOT_MAPPED;
                            end else begin
                                tbl_req.we            = 1'b1;
                                tbl_req.wdata         = tbl_rdata;
                                tbl_req.wdata.present = 1'b0;
                            end
                        end
                        default: begin
                            if (!tbl_rdata.present) begin
                                out_status_next = ST_NOT_MAPPED;
                            end else begin
                                out_addr_next  = {tbl_rdata.frame, va_reg[PAGE_SHIFT-1:0]};
                                out_flags_next = {tbl_rdata.user, tbl_rdata.writable};
                            end
                        end
                    endcase
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
        op_reg         <= op_next;
        va_reg         <= va_next;
        pa_reg         <= pa_next;
        fl_reg         <= fl_next;
        taddr_reg      <= taddr_next;
        out_addr_reg   <= out_addr_next;
        out_flags_reg  <= out_flags_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_addr   = out_addr_reg;
    assign out_flags  = out_flags_reg;
    assign out_status = out_status_reg;

endmodule

// ===== src/two_level_page_table_engine_core.sv =====
// ============================================================================
// two_level_page_table_engine_core: two-level page table engine
// Map, unmap and translate over a page directory and a pool of page tables
// held in two single-port synchronous memories.
// ============================================================================
// After reset the engine clears both stores, one entry a cycle, over all
// TABLE_SLOTS * 1024 table entries (16384 at the default size), with
// s_tready low. It then works on one transaction at a time. A transaction
// that ends at the directory lookup (misaligned, reserved directory,
// directory entry absent, pool exhausted, unused operation) has its result
// registered from the directory state, once the directory read is back.
// All others go on to a dependent table read and have their result
// registered from the table state once that read is back. A finished result
// waits in an output register, so the next transaction is accepted while it
// is still held; a held result that is not taken stalls the following
// transaction at its last step until m_tready frees the register.
module two_level_page_table_engine_core
    import ptab_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // virt_addr[31:0], phys_addr_in[63:32], map_flags[65:64], zero
    input  logic [1:0]  s_tuser,   // operation[1:0]
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // phys_addr_out[31:0], entry_flags[33:32], zero
    output logic [2:0]  m_tuser    // status[2:0]
);

    dir_req_t          dir_req;
    tbl_req_t          tbl_req;
    dir_entry_t        dir_rdata;
    tbl_entry_t        tbl_rdata;
    logic [ADDR_W-1:0] out_addr;
    logic [1:0]        out_flags;
    status_t           out_status;

    // Walk sequencer.
    ptab_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (op_t'(s_tuser)),
        .in_va      (s_tdata[31:0]),
        .in_pa      (s_tdata[63:32]),
        .in_flags   (s_tdata[65:64]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_addr   (out_addr),
        .out_flags  (out_flags),
        .out_status (out_status),
        .dir_req    (dir_req),
        .dir_rdata  (dir_rdata),
        .tbl_req    (tbl_req),
        .tbl_rdata  (tbl_rdata)
    );

    // Page directory store.
    ptab_ram #(
        .DEPTH (DIR_ENTRIES),
        .WIDTH (DIR_W)
    ) u_dir_ram (
        .aclk  (aclk),
        .we    (dir_req.we),
        .re    (dir_req.re),
        .addr  (dir_req.addr),
        .wdata (dir_req.wdata),
        .rdata (dir_rdata)
    );

    // Page table pool store.
    ptab_ram #(
        .DEPTH (TBL_DEPTH),
        .WIDTH (TBL_W)
    ) u_tbl_ram (
        .aclk  (aclk),
        .we    (tbl_req.we),
        .re    (tbl_req.re),
        .addr  (tbl_req.addr),
        .wdata (tbl_req.wdata),
        .rdata (tbl_rdata)
    );

    // Result packing.
    assign m_tdata = {6'd0, out_flags, out_addr};
    assign m_tuser = out_status;

endmodule

// ===== verif/ptab_walk_checker.sv =====
// ============================================================================
// ptab_walk_checker: result checker of the two-level page table engine
// Watches the request and result channels, keeps its own copy of the page
// directory, the page table pool and the slot counter, works out the result
// of every accepted request and compares it field by field in arrival order.
// ============================================================================
`timescale 1ns / 100ps

module ptab_walk_checker
    import ptab_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // virt_addr[31:0], phys_addr_in[63:32], map_flags[65:64], zero
    input  logic [1:0]  s_tuser,   // operation[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // phys_addr_out[31:0], entry_flags[33:32], zero
    input  logic [2:0]  m_tuser,   // status[2:0]
    output int          fail_count,
    output int          pending
);

    // One predicted result transaction.
    typedef struct packed {
        logic [31:0] phys;
        logic [1:0]  flags;
        status_t     status;
    } walk_result_t;

    // Shadow copy of the engine state.
    logic         dir_mapped  [DIR_ENTRIES];
    int unsigned  dir_slot_no [DIR_ENTRIES];
    tbl_entry_t   page_entry  [TBL_DEPTH];
    int unsigned  slots_taken;

    walk_result_t walk_results_q[$];
    walk_result_t oldest;
    int           errors = 0;

    // Applies one request to the shadow state and returns its result.
    function automatic walk_result_t predict_walk(op_t op, logic [31:0] va,
                                                  logic [31:0] pa, logic [1:0] fl);
        walk_result_t r;
        int unsigned  dir_idx;
        int unsigned  pos;
        r.phys   = '0;
        r.flags  = '0;
        r.status = ST_OK;
        dir_idx  = 32'(va[31:22]);
        // Slot number defaults to zero, so the position is always in range.
        pos      = dir_slot_no[dir_idx] * TABLE_ENTRIES + 32'(va[21:12]);
        case (op)
            OP_MAP: begin
                if (va[11:0] != 0 || pa[11:0] != 0) begin
                    r.status = ST_MISALIGNED;
                end else if (dir_idx >= DIR_ENTRIES - RESERVED_DIR_ENTRIES) begin
                    r.status = ST_RESERVED;
                end else if (!dir_mapped[dir_idx] && slots_taken >= TABLE_SLOTS) begin
                    r.status = ST_NO_SLOT;
                end else begin
                    // A fresh directory entry takes the next slot for good.
                    if (!dir_mapped[dir_idx]) begin
                        dir_mapped[dir_idx]  = 1'b1;
                        dir_slot_no[dir_idx] = slots_taken;
                        for (int k = 0; k < TABLE_ENTRIES; k++)
                            page_entry[slots_taken * TABLE_ENTRIES + k] = '0;
                        slots_taken++;
                        pos = dir_slot_no[dir_idx] * TABLE_ENTRIES + 32'(va[21:12]);
                    end
                    if (page_entry[pos].present) begin
                        r.status = ST_ALREADY;
                    end else begin
                        page_entry[pos].present  = 1'b1;
                        page_entry[pos].user     = fl[1];
                        page_entry[pos].writable = fl[0];
                        page_entry[pos].frame    = pa[31:12];
                    end
                end
            end
            OP_UNMAP: begin
                if (va[11:0] != 0)
                    r.status = ST_MISALIGNED;
                else if (dir_idx >= DIR_ENTRIES - RESERVED_DIR_ENTRIES)
                    r.status = ST_RESERVED;
                else if (!dir_mapped[dir_idx] || !page_entry[pos].present)
                    r.status = ST_NOT_MAPPED;
                else
                    page_entry[pos].present = 1'b0;
            end
            OP_XLATE: begin
                // No alignment or reserved check; the offset passes through.
                if (!dir_mapped[dir_idx] || !page_entry[pos].present) begin
                    r.status = ST_NOT_MAPPED;
                end else begin
                    r.phys  = {page_entry[pos].frame, va[11:0]};
                    r.flags = {page_entry[pos].user, page_entry[pos].writable};
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Compare results first, then record the new request of the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIR_ENTRIES; k++) begin
                dir_mapped[k]  = 1'b0;
                dir_slot_no[k] = 0;
            end
            for (int k = 0; k < TBL_DEPTH; k++)
                page_entry[k] = '0;
            slots_taken = 0;
            walk_results_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (walk_results_q.size() == 0) begin
                    $error("unexpected result transaction: phys_addr_out %h, status %0d",
                           m_tdata[31:0], m_tuser);
                    errors++;
                end else begin
                    oldest = walk_results_q.pop_front();
                    if (m_tdata[31:0] !== oldest.phys) begin
                        $error("phys_addr_out mismatch: expected %h, actual %h",
                               oldest.phys, m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[33:32] !== oldest.flags) begin
                        $error("entry_flags mismatch: expected %0d, actual %0d",
                               oldest.flags, m_tdata[33:32]);
                        errors++;
                    end
                    if (m_tuser !== oldest.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest.status, m_tuser);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                walk_results_q.push_back(predict_walk(op_t'(s_tuser), s_tdata[31:0],
                                                      s_tdata[63:32], s_tdata[65:64]));
        end
        fail_count <= errors;
        pending    <= walk_results_q.size();
    end

endmodule

// ===== verif/tb_two_level_page_table_engine_core.sv =====
// ============================================================================
// tb_two_level_page_table_engine_core: testbench of the page table engine
// Sends a directed set of map, unmap and translate requests covering the
// alignment, reserved directory, already mapped and not mapped cases, then
// random requests aimed at a few hot directory and table indexes so that
// entries are hit again and the table pool runs dry. Both channels idle at
// random; the checker module predicts and compares every result.
// ============================================================================
`timescale 1ns / 100ps

module tb_two_level_page_table_engine_core
    import ptab_pkg::*;
();

    localparam int RANDOM_REQUESTS = 600;
    localparam int DRAIN_CYCLES    = 16;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    op_t         s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    int          fail_count;
    int          pending;
    int          sent_count;
    int          taken_count;

    two_level_page_table_engine_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ptab_walk_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 10 ns clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard limit on the run, well beyond the clearing pass and all traffic.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Sends one request transaction after a random gap; some stretches run
    // back to back.
    task automatic send_request(input op_t op, input logic [31:0] va,
                                input logic [31:0] pa, input logic [1:0] fl);
        int gap;
        gap = (sent_count % 64 < 16) ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, fl, pa, va};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        sent_count++;
    endtask

    // Page-aligned virtual address, mostly at a few hot directory and table
    // indexes so that entries are revisited.
    function automatic logic [31:0] pick_page_va();
        logic [9:0] dir_idx;
        logic [9:0] tbl_idx;
        if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 7))
                0:       dir_idx = 10'd0;
                1:       dir_idx = 10'd1;
                2:       dir_idx = 10'd2;
                3:       dir_idx = 10'd3;
                4:       dir_idx = 10'd341;
                5:       dir_idx = 10'd682;
                6:       dir_idx = 10'd1022;
                default: dir_idx = 10'd1023;
            endcase
        end else begin
            dir_idx = 10'($urandom_range(0, 1023));
        end
        if ($urandom_range(0, 9) < 8) begin
            case ($urandom_range(0, 7))
                0:       tbl_idx = 10'd0;
                1:       tbl_idx = 10'd1;
                2:       tbl_idx = 10'd2;
                3:       tbl_idx = 10'd3;
                4:       tbl_idx = 10'd511;
                5:       tbl_idx = 10'd512;
                6:       tbl_idx = 10'd1022;
                default: tbl_idx = 10'd1023;
            endcase
        end else begin
            tbl_idx = 10'($urandom_range(0, 1023));
        end
        return {dir_idx, tbl_idx, 12'h000};
    endfunction

    // Result side: a random stall before each result, with quiet stretches.
    initial begin
        int stall;
        m_tready    = 1'b0;
        taken_count = 0;
        forever begin
            stall = (taken_count % 64 >= 32 && taken_count % 64 < 48) ? 0
                                                                     : $urandom_range(0, 5);
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            taken_count++;
        end
    end

    // Reset, stimulus and verdict.
    initial begin
        int          pick;
        op_t         op;
        logic [31:0] va;
        logic [31:0] pa;
        logic [1:0]  fl;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_MAP;
        sent_count = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed requests.
        send_request(OP_XLATE, 32'h0000_0000, 32'h0000_0000, 2'd0);
        send_request(OP_MAP,   32'h0000_0000, 32'hFFFF_F000, 2'd3);
        send_request(OP_XLATE, 32'h0000_0FFF, 32'h0000_0000, 2'd0);
        send_request(OP_MAP,   32'h0000_0000, 32'h0000_1000, 2'd0);
        send_request(OP_MAP,   32'h0040_0001, 32'h0000_1000, 2'd1);
        send_request(OP_MAP,   32'h0040_0000, 32'h0000_0800, 2'd1);
        send_request(OP_MAP,   32'hFFC0_0000, 32'h0000_2000, 2'd3);
        send_request(OP_UNMAP, 32'hFFFF_F000, 32'h0000_0000, 2'd0);
        send_request(OP_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 2'd0);
        send_request(OP_MAP,   32'hFF80_0000, 32'h1234_5000, 2'd1);
        send_request(OP_XLATE, 32'hFFBF_FABC, 32'h0000_0000, 2'd0);
        send_request(OP_XLATE, 32'hFF80_0ABC, 32'h0000_0000, 2'd0);
        send_request(OP_UNMAP, 32'h0000_0800, 32'h0000_0000, 2'd0);
        send_request(OP_UNMAP, 32'h0000_1000, 32'h0000_0000, 2'd0);
        send_request(OP_UNMAP, 32'h0000_0000, 32'h0000_0000, 2'd0);
        send_request(OP_UNMAP, 32'h0000_0000, 32'h0000_0000, 2'd0);
        send_request(OP_XLATE, 32'h0000_0123, 32'h0000_0000, 2'd0);
        send_request(OP_MAP,   32'h0000_0000, 32'h0000_0000, 2'd2);
        send_request(OP_XLATE, 32'h0000_0FFF, 32'h0000_0000, 2'd0);
        send_request(OP_MAP,   32'h003F_F000, 32'hABCD_E000, 2'd0);
        send_request(OP_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
        send_request(OP_NONE,  32'h0000_0000, 32'h0000_0000, 2'd0);
        send_request(OP_UNMAP, 32'h0040_0000, 32'h0000_0000, 2'd0);

        // Random requests; fresh directory indexes use up the table pool.
        repeat (RANDOM_REQUESTS) begin
            pick = $urandom_range(0, 99);
            op   = (pick < 38) ? OP_MAP : (pick < 58) ? OP_UNMAP :
                   (pick < 95) ? OP_XLATE : OP_NONE;
            va   = pick_page_va();
            pa   = $urandom();
            fl   = 2'($urandom_range(0, 3));
            if (op == OP_XLATE || $urandom_range(0, 11) == 0)
                va[11:0] = 12'($urandom_range(0, 4095));
            if ($urandom_range(0, 11) != 0)
                pa[11:0] = 12'h000;
            if (op == OP_NONE)
                va = $urandom();
            send_request(op, va, pa, fl);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Let the checker see the last request, then drain.
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
